// ----- src/i2c_master_byte_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// i2c master byte engine assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define I2CMB_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define I2CMB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/i2cmb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmb_pkg
// types, codes and constants shared by the i2c master byte engine
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmb_pkg;

   localparam int DATA_BITS   = 8;
   localparam int BIT_CNT_W   = 4;
   localparam int TICK_W      = 8;
   localparam int CMD_W       = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int QUEUE_DEPTH = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_START = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REP   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

   // queue entry kinds
   localparam logic [1:0] KIND_NOP  = 2'd0;
   localparam logic [1:0] KIND_TICK = 2'd1;
   localparam logic [1:0] KIND_CMD  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HOLD        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_REST    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_REST   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START_SETUP = 3'd5;

   // register reset values
   localparam logic [TICK_W-1:0] RST_HOLD        = 8'd2;
   localparam logic [TICK_W-1:0] RST_LOW_REST    = 8'd2;
   localparam logic [TICK_W-1:0] RST_HIGH        = 8'd3;
   localparam logic [TICK_W-1:0] RST_HIGH_REST   = 8'd2;
   localparam logic [TICK_W-1:0] RST_IDLE        = 8'd5;
   localparam logic [TICK_W-1:0] RST_START_SETUP = 8'd1;

   typedef struct packed {
      logic                 req_type;
      logic [CMD_W-1:0]     command;
      logic [DATA_BITS-1:0] wr_data;
      logic                 send_ack;
      logic                 sda_in;
   } req_payload_type;

   typedef struct packed {
      logic                 scl_out;
      logic                 sda_out;
      logic                 busy_res;
      logic                 done_res;
      logic [DATA_BITS-1:0] rd_data;
      logic                 ack_seen;
      logic                 start_refused;
   } rsp_payload_type;

   typedef struct packed {
      logic [TICK_W-1:0] hold;
      logic [TICK_W-1:0] low_rest;
      logic [TICK_W-1:0] high;
      logic [TICK_W-1:0] high_rest;
      logic [TICK_W-1:0] idle;
      logic [TICK_W-1:0] start_setup;
   } timing_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [CMD_W-1:0]     command;
      logic [DATA_BITS-1:0] wr_data;
      logic                 send_ack;
      logic                 sda_in;
   } queue_entry_type;

endpackage

`default_nettype wire

// ----- src/i2c_master_byte_engine_core.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// tick-driven i2c master: start, repeated start, write, read and stop
// ----------------------------------------------------------------------------
// Every request transaction is either one time tick or a new command and
// yields exactly one response transaction carrying the scl/sda drive levels
// and status after it. The block takes one request per clock cycle and keeps
// that rate as long as responses are taken; a request's response is offered
// once the request has passed through the input queue and is held while the
// response is stalled. The engine's phase step registers the response,
// updating all bus state from its registered state. Timing registers may be
// written at any time the engine is idle and take effect on the next command.
`default_nettype none

module i2c_master_byte_engine_core #(
   parameter int QUEUE_DEPTH = i2cmb_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  i2cmb_pkg::req_payload_type             req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output i2cmb_pkg::rsp_payload_type             rsp_data,
   input  wire logic                              csr_wr_en,
   input  wire logic [i2cmb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [i2cmb_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   i2cmb_pkg::timing_type      timing;
   i2cmb_pkg::queue_entry_type push_entry;
   i2cmb_pkg::queue_entry_type q_entry;
   logic                       push_valid, q_full, q_valid, q_pop;

   i2cmb_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .timing      (timing)
   );

   i2cmb_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   i2cmb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   i2cmb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .timing    (timing),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- src/i2cmb_regs.sv -----
// ----------------------------------------------------------------------------
// i2cmb_regs
// timing registers written through the csr write port
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmb_regs (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [i2cmb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [i2cmb_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output i2cmb_pkg::timing_type                  timing
);

   i2cmb_pkg::timing_type timing_ff;
   i2cmb_pkg::timing_type timing_in;

   always_comb begin
      timing_in = timing_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            i2cmb_pkg::REG_HOLD:        timing_in.hold        = csr_wr_data;
            i2cmb_pkg::REG_LOW_REST:    timing_in.low_rest    = csr_wr_data;
            i2cmb_pkg::REG_HIGH:        timing_in.high        = csr_wr_data;
            i2cmb_pkg::REG_HIGH_REST:   timing_in.high_rest   = csr_wr_data;
            i2cmb_pkg::REG_IDLE:        timing_in.idle        = csr_wr_data;
            i2cmb_pkg::REG_START_SETUP: timing_in.start_setup = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.hold        <= i2cmb_pkg::RST_HOLD;
         timing_ff.low_rest    <= i2cmb_pkg::RST_LOW_REST;
         timing_ff.high        <= i2cmb_pkg::RST_HIGH;
         timing_ff.high_rest   <= i2cmb_pkg::RST_HIGH_REST;
         timing_ff.idle        <= i2cmb_pkg::RST_IDLE;
         timing_ff.start_setup <= i2cmb_pkg::RST_START_SETUP;
      end else begin
         timing_ff <= timing_in;
      end
   end

   assign timing = timing_ff;

endmodule

`default_nettype wire

// ----- src/i2cmb_front.sv -----
// ----------------------------------------------------------------------------
// i2cmb_front
// accepts request transactions and sorts them into tick, command or no-op
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmb_front (
   input  wire logic                   req_valid,
   input  i2cmb_pkg::req_payload_type  req_data,
   output logic                        req_stall,
   input  wire logic                   q_full,
   output logic                        push_valid,
   output i2cmb_pkg::queue_entry_type  push_entry
);

   always_comb begin
      push_entry.command  = req_data.command;
      push_entry.wr_data  = req_data.wr_data;
      push_entry.send_ack = req_data.send_ack;
      push_entry.sda_in   = req_data.sda_in;
      if (!req_data.req_type) begin
         push_entry.kind = i2cmb_pkg::KIND_TICK;
      end else begin
         unique case (req_data.command) inside
            i2cmb_pkg::CMD_START, i2cmb_pkg::CMD_REP, i2cmb_pkg::CMD_WRITE,
            i2cmb_pkg::CMD_READ, i2cmb_pkg::CMD_STOP:
               push_entry.kind = i2cmb_pkg::KIND_CMD;
            default:
               push_entry.kind = i2cmb_pkg::KIND_NOP;
         endcase
      end
   end

   assign req_stall  = q_full;
   assign push_valid = req_valid && !q_full;

endmodule

`default_nettype wire

// ----- src/i2cmb_queue.sv -----
// ----------------------------------------------------------------------------
// i2cmb_queue
// short fifo between the front end and the bus engine
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmb_queue #(
   parameter int DEPTH = i2cmb_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  i2cmb_pkg::queue_entry_type  push_entry,
   output logic                        q_full,
   output logic                        q_valid,
   output i2cmb_pkg::queue_entry_type  q_entry,
   input  wire logic                   q_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   i2cmb_pkg::queue_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      nxt = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
      return nxt;
   endfunction

   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_entry = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- src/i2cmb_engine.sv -----
// ----------------------------------------------------------------------------
// i2cmb_engine
// scl/sda phase sequencer, one queued transaction per cycle while responses are not stalled
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmb_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  i2cmb_pkg::timing_type       timing,
   input  wire logic                   q_valid,
   input  i2cmb_pkg::queue_entry_type  q_entry,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output i2cmb_pkg::rsp_payload_type  rsp_data
);

   localparam int PH_W = 5;
   localparam int DB   = i2cmb_pkg::DATA_BITS;
   localparam int BW   = i2cmb_pkg::BIT_CNT_W;
   localparam int TW   = i2cmb_pkg::TICK_W;

   localparam logic [PH_W-1:0] PH_IDLE      = 5'd0;
   localparam logic [PH_W-1:0] PH_ST_SETUP  = 5'd1;
   localparam logic [PH_W-1:0] PH_ST_HOLD   = 5'd2;
   localparam logic [PH_W-1:0] PH_LOW_HOLD  = 5'd3;
   localparam logic [PH_W-1:0] PH_LOW_REST  = 5'd4;
   localparam logic [PH_W-1:0] PH_HIGH_PRE  = 5'd5;
   localparam logic [PH_W-1:0] PH_HIGH_POST = 5'd6;
   localparam logic [PH_W-1:0] PH_HIGH_FULL = 5'd7;
   localparam logic [PH_W-1:0] PH_RS_SETUP  = 5'd8;
   localparam logic [PH_W-1:0] PH_RS_HOLD   = 5'd9;
   localparam logic [PH_W-1:0] PH_BUS_FREE  = 5'd10;

   logic [PH_W-1:0]              phase_ff, phase_in;
   logic [BW-1:0]                bit_count_ff, bit_count_in;
   logic [DB-1:0]                shift_ff, shift_in;
   logic [TW-1:0]                tick_ff, tick_in;
   logic [i2cmb_pkg::CMD_W-1:0]  active_cmd_ff, active_cmd_in;
   logic                         ack_ff, ack_in;
   logic                         nack_ff, nack_in;
   logic                         scl_ff, scl_in;
   logic                         sda_ff, sda_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   i2cmb_pkg::rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic          done, refused, data_slot;
   logic [DB-1:0] rd_byte;
   logic [TW-1:0] w_hold, w_low_rest, w_high, w_high_rest, w_idle, w_setup;

   function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] t);
      logic [TW-1:0] r;
      r = (t == '0) ? TW'(1) : t;
      return r;
   endfunction

   assign w_hold      = at_least_one(timing.hold);
   assign w_low_rest  = at_least_one(timing.low_rest);
   assign w_high      = at_least_one(timing.high);
   assign w_high_rest = at_least_one(timing.high_rest);
   assign w_idle      = at_least_one(timing.idle);
   assign w_setup     = at_least_one(timing.start_setup);

   assign q_pop     = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign data_slot = (bit_count_ff < BW'(DB));

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      tick_in       = tick_ff;
      active_cmd_in = active_cmd_ff;
      ack_in        = ack_ff;
      nack_in       = nack_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      done          = 1'b0;
      refused       = 1'b0;
      rd_byte       = '0;

      if (q_pop) begin
         unique case (q_entry.kind)
            i2cmb_pkg::KIND_CMD: begin
               if (phase_ff == PH_IDLE) begin
                  active_cmd_in = q_entry.command;
                  bit_count_in  = '0;
                  if (q_entry.command == i2cmb_pkg::CMD_START) begin
                     ack_in = q_entry.sda_in;
                     if (!q_entry.sda_in) begin
                        ack_in   = 1'b0;
                        refused  = 1'b1;
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                        tick_in  = '0;
                     end else begin
                        scl_in   = 1'b1;
                        phase_in = PH_ST_SETUP;
                        tick_in  = w_setup;
                     end
                  end else begin
                     if (q_entry.command == i2cmb_pkg::CMD_WRITE) begin
                        shift_in = q_entry.wr_data;
                     end
                     if (q_entry.command == i2cmb_pkg::CMD_READ) begin
                        shift_in = '0;
                        nack_in  = !q_entry.send_ack;
                     end
                     scl_in   = 1'b0;
                     phase_in = PH_LOW_HOLD;
                     tick_in  = w_hold;
                  end
               end
            end
            i2cmb_pkg::KIND_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (tick_ff > TW'(1)) begin
                     tick_in = tick_ff - 1'b1;
                  end else if (phase_ff == PH_HIGH_PRE) begin
                     if (active_cmd_ff == i2cmb_pkg::CMD_WRITE) begin
                        ack_in = !q_entry.sda_in;
                     end else begin
                        shift_in = {shift_ff[DB-2:0], q_entry.sda_in};
                     end
                     phase_in = PH_HIGH_POST;
                     tick_in  = w_high_rest;
                  end else if (phase_ff == PH_HIGH_FULL &&
                               active_cmd_ff == i2cmb_pkg::CMD_REP) begin
                     ack_in = q_entry.sda_in;
                     if (!q_entry.sda_in) begin
                        ack_in   = 1'b0;
                        refused  = 1'b1;
                        done     = 1'b1;
                        phase_in = PH_IDLE;
                        tick_in  = '0;
                     end else begin
                        phase_in = PH_RS_SETUP;
                        tick_in  = w_setup;
                     end
                  end else begin
                     unique case (phase_ff) inside
                        PH_ST_SETUP: begin
                           sda_in   = 1'b0;
                           phase_in = PH_ST_HOLD;
                           tick_in  = w_high;
                        end
                        PH_LOW_HOLD: begin
                           if (active_cmd_ff == i2cmb_pkg::CMD_WRITE) begin
                              if (data_slot) begin
                                 sda_in   = shift_ff[DB-1];
                                 shift_in = {shift_ff[DB-2:0], 1'b0};
                              end else begin
                                 sda_in = 1'b1;
                              end
                           end else if (active_cmd_ff == i2cmb_pkg::CMD_READ) begin
                              sda_in = data_slot ? 1'b1 : nack_ff;
                           end else if (active_cmd_ff == i2cmb_pkg::CMD_STOP) begin
                              sda_in = 1'b0;
                           end else begin
                              sda_in = 1'b1;
                           end
                           phase_in = PH_LOW_REST;
                           tick_in  = w_low_rest;
                        end
                        PH_LOW_REST: begin
                           scl_in = 1'b1;
                           if ((active_cmd_ff == i2cmb_pkg::CMD_WRITE && !data_slot) ||
                               (active_cmd_ff == i2cmb_pkg::CMD_READ && data_slot)) begin
                              phase_in = PH_HIGH_PRE;
                              tick_in  = w_hold;
                           end else begin
                              phase_in = PH_HIGH_FULL;
                              tick_in  = w_high;
                           end
                        end
                        PH_HIGH_POST: begin
                           if (active_cmd_ff == i2cmb_pkg::CMD_READ) begin
                              bit_count_in = bit_count_ff + 1'b1;
                              scl_in       = 1'b0;
                              phase_in     = PH_LOW_HOLD;
                              tick_in      = w_hold;
                           end else begin
                              done     = 1'b1;
                              phase_in = PH_IDLE;
                              tick_in  = '0;
                           end
                        end
                        PH_HIGH_FULL: begin
                           if (active_cmd_ff == i2cmb_pkg::CMD_WRITE) begin
                              bit_count_in = bit_count_ff + 1'b1;
                              scl_in       = 1'b0;
                              phase_in     = PH_LOW_HOLD;
                              tick_in      = w_hold;
                           end else if (active_cmd_ff == i2cmb_pkg::CMD_STOP) begin
                              sda_in   = 1'b1;
                              phase_in = PH_BUS_FREE;
                              tick_in  = w_idle;
                           end else begin
                              done     = 1'b1;
                              phase_in = PH_IDLE;
                              tick_in  = '0;
                           end
                        end
                        PH_RS_SETUP: begin
                           sda_in   = 1'b0;
                           phase_in = PH_RS_HOLD;
                           tick_in  = w_hold;
                        end
                        PH_ST_HOLD, PH_RS_HOLD, PH_BUS_FREE: begin
                           done     = 1'b1;
                           phase_in = PH_IDLE;
                           tick_in  = '0;
                        end
                        default: begin
                           phase_in = PH_IDLE;
                           tick_in  = '0;
                        end
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end

      if (done && active_cmd_in == i2cmb_pkg::CMD_READ) begin
         rd_byte = shift_in;
      end

      rsp_data_in.scl_out       = scl_in;
      rsp_data_in.sda_out       = sda_in;
      rsp_data_in.busy_res      = (phase_in != PH_IDLE);
      rsp_data_in.done_res      = done;
      rsp_data_in.rd_data       = rd_byte;
      rsp_data_in.ack_seen      = ack_in;
      rsp_data_in.start_refused = refused;

      rsp_valid_in = q_pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         tick_ff       <= '0;
         active_cmd_ff <= '0;
         ack_ff        <= 1'b0;
         nack_ff       <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         tick_ff       <= tick_in;
         active_cmd_ff <= active_cmd_in;
         ack_ff        <= ack_in;
         nack_ff       <= nack_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- src/i2cmb_checker.sv -----
// ----------------------------------------------------------------------------
// i2cmb_checker
// port-level checks on the response channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_byte_engine_core_macros.svh"

module i2cmb_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input i2cmb_pkg::rsp_payload_type rsp_data
);

   `I2CMB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response transaction changed")
   `I2CMB_ASSERT(a_done_idle, clock, reset, rsp_valid && rsp_data.done_res, !rsp_data.busy_res, "done reported while still busy")
   `I2CMB_ASSERT(a_refuse_done, clock, reset, rsp_valid && rsp_data.start_refused, rsp_data.done_res && !rsp_data.ack_seen && rsp_data.scl_out, "refused start without done or with bus change")
   `I2CMB_ASSERT(a_rd_only_done, clock, reset, rsp_valid && !rsp_data.done_res, rsp_data.rd_data == '0, "read data outside a done transaction")

endmodule

bind i2c_master_byte_engine_core i2cmb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- tb/i2c_master_byte_engine_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core_checker
// watches the request, response and register ports of the byte engine, runs
// its own model of the scl/sda phase sequence for every accepted request and
// compares each accepted response field by field with the oldest prediction
// ----------------------------------------------------------------------------

module i2c_master_byte_engine_core_checker
   import i2cmb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  req_payload_type            req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  rsp_payload_type            rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   input  wire logic                  end_of_run,
   output int unsigned                failures
);

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_ST_SETUP  = 5'd1,
      PH_ST_HOLD   = 5'd2,
      PH_LOW_HOLD  = 5'd3,
      PH_LOW_REST  = 5'd4,
      PH_HIGH_PRE  = 5'd5,
      PH_HIGH_POST = 5'd6,
      PH_HIGH_FULL = 5'd7,
      PH_RS_SETUP  = 5'd8,
      PH_RS_HOLD   = 5'd9,
      PH_BUS_FREE  = 5'd10
   } bus_phase_type;

   timing_type           tcfg;
   bus_phase_type        bus_phase;
   logic [BIT_CNT_W-1:0] bit_cnt;
   logic [DATA_BITS-1:0] shifter;
   logic [TICK_W-1:0]    ticks_left;
   logic [CMD_W-1:0]     cur_cmd;
   logic                 ack_bit;
   logic                 nack_bit;
   logic                 scl_lvl;
   logic                 sda_lvl;
   logic                 step_done;
   logic                 step_refused;
   logic [DATA_BITS-1:0] step_rd;

   rsp_payload_type      expected_levels[$];
   int unsigned          rsp_seen = 0;

   initial failures = 0;

   task automatic report(input string msg);
      $display("%0t  mismatch: %s", $time, msg);
      failures++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report($sformatf("response %0d %s is %0h, predicted %0h",
                          rsp_seen, name, got, want));
   endtask

   function automatic void arm(input bus_phase_type nxt, input logic [TICK_W-1:0] n);
      bus_phase  = nxt;
      ticks_left = (n == '0) ? TICK_W'(1) : n;
   endfunction

   function automatic void complete();
      bus_phase  = PH_IDLE;
      ticks_left = '0;
      step_done  = 1'b1;
      if (cur_cmd == CMD_READ)
         step_rd = shifter;
   endfunction

   function automatic void refuse_start();
      ack_bit      = 1'b0;
      step_refused = 1'b1;
      complete();
   endfunction

   function automatic void advance_bit();
      bit_cnt = bit_cnt + 1'b1;
      scl_lvl = 1'b0;
      arm(PH_LOW_HOLD, tcfg.hold);
   endfunction

   function automatic rsp_payload_type predict_bus_levels(input req_payload_type rq);
      rsp_payload_type r;
      logic            data_slot;
      step_done    = 1'b0;
      step_refused = 1'b0;
      step_rd      = '0;
      data_slot    = (bit_cnt < DATA_BITS);
      if (rq.req_type) begin
         if (bus_phase == PH_IDLE && rq.command <= CMD_STOP) begin
            cur_cmd = rq.command;
            bit_cnt = '0;
            if (rq.command == CMD_START) begin
               ack_bit = rq.sda_in;
               if (!rq.sda_in) begin
                  refuse_start();
               end else begin
                  scl_lvl = 1'b1;
                  arm(PH_ST_SETUP, tcfg.start_setup);
               end
            end else begin
               if (rq.command == CMD_WRITE)
                  shifter = rq.wr_data;
               if (rq.command == CMD_READ) begin
                  shifter  = '0;
                  nack_bit = !rq.send_ack;
               end
               scl_lvl = 1'b0;
               arm(PH_LOW_HOLD, tcfg.hold);
            end
         end
      end else if (bus_phase != PH_IDLE) begin
         if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
         end else if (bus_phase == PH_HIGH_PRE) begin
            // sample point inside scl high
            if (cur_cmd == CMD_WRITE)
               ack_bit = !rq.sda_in;
            else
               shifter = {shifter[DATA_BITS-2:0], rq.sda_in};
            arm(PH_HIGH_POST, tcfg.high_rest);
         end else if (bus_phase == PH_HIGH_FULL && cur_cmd == CMD_REP) begin
            ack_bit = rq.sda_in;
            if (!rq.sda_in)
               refuse_start();
            else
               arm(PH_RS_SETUP, tcfg.start_setup);
         end else begin
            case (bus_phase)
               PH_ST_SETUP: begin
                  sda_lvl = 1'b0;
                  arm(PH_ST_HOLD, tcfg.high);
               end
               PH_LOW_HOLD: begin
                  if (cur_cmd == CMD_WRITE) begin
                     if (data_slot) begin
                        sda_lvl = shifter[DATA_BITS-1];
                        shifter = shifter << 1;
                     end else begin
                        sda_lvl = 1'b1;
                     end
                  end else if (cur_cmd == CMD_READ) begin
                     sda_lvl = data_slot ? 1'b1 : nack_bit;
                  end else if (cur_cmd == CMD_STOP) begin
                     sda_lvl = 1'b0;
                  end else begin
                     sda_lvl = 1'b1;
                  end
                  arm(PH_LOW_REST, tcfg.low_rest);
               end
               PH_LOW_REST: begin
                  scl_lvl = 1'b1;
                  if ((cur_cmd == CMD_WRITE && !data_slot) ||
                      (cur_cmd == CMD_READ && data_slot))
                     arm(PH_HIGH_PRE, tcfg.hold);
                  else
                     arm(PH_HIGH_FULL, tcfg.high);
               end
               PH_HIGH_POST: begin
                  if (cur_cmd == CMD_READ)
                     advance_bit();
                  else
                     complete();
               end
               PH_HIGH_FULL: begin
                  if (cur_cmd == CMD_WRITE) begin
                     advance_bit();
                  end else if (cur_cmd == CMD_STOP) begin
                     sda_lvl = 1'b1;
                     arm(PH_BUS_FREE, tcfg.idle);
                  end else begin
                     complete();
                  end
               end
               PH_RS_SETUP: begin
                  sda_lvl = 1'b0;
                  arm(PH_RS_HOLD, tcfg.hold);
               end
               PH_ST_HOLD, PH_RS_HOLD, PH_BUS_FREE: begin
                  complete();
               end
               default: begin
                  bus_phase  = PH_IDLE;
                  ticks_left = '0;
               end
            endcase
         end
      end
      r.scl_out       = scl_lvl;
      r.sda_out       = sda_lvl;
      r.busy_res      = (bus_phase != PH_IDLE);
      r.done_res      = step_done;
      r.rd_data       = step_rd;
      r.ack_seen      = ack_bit;
      r.start_refused = step_refused;
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         tcfg       = '{hold: RST_HOLD, low_rest: RST_LOW_REST, high: RST_HIGH,
                        high_rest: RST_HIGH_REST, idle: RST_IDLE,
                        start_setup: RST_START_SETUP};
         bus_phase  = PH_IDLE;
         bit_cnt    = '0;
         shifter    = '0;
         ticks_left = '0;
         cur_cmd    = '0;
         ack_bit    = 1'b0;
         nack_bit   = 1'b0;
         scl_lvl    = 1'b1;
         sda_lvl    = 1'b1;
         expected_levels.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_HOLD:        tcfg.hold        = csr_wr_data;
               REG_LOW_REST:    tcfg.low_rest    = csr_wr_data;
               REG_HIGH:        tcfg.high        = csr_wr_data;
               REG_HIGH_REST:   tcfg.high_rest   = csr_wr_data;
               REG_IDLE:        tcfg.idle        = csr_wr_data;
               REG_START_SETUP: tcfg.start_setup = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               report($sformatf("response %0d arrived with nothing outstanding", rsp_seen));
            end else begin
               want = expected_levels.pop_front();
               check_field("scl_out", 8'(rsp_data.scl_out), 8'(want.scl_out));
               check_field("sda_out", 8'(rsp_data.sda_out), 8'(want.sda_out));
               check_field("busy_res", 8'(rsp_data.busy_res), 8'(want.busy_res));
               check_field("done_res", 8'(rsp_data.done_res), 8'(want.done_res));
               check_field("rd_data", rsp_data.rd_data, want.rd_data);
               check_field("ack_seen", 8'(rsp_data.ack_seen), 8'(want.ack_seen));
               check_field("start_refused", 8'(rsp_data.start_refused),
                           8'(want.start_refused));
            end
            rsp_seen++;
         end
         if (req_valid && !req_stall)
            expected_levels.push_back(predict_bus_levels(req_data));
         if (end_of_run) begin
            while (expected_levels.size() > 0) begin
               report("predicted response never arrived");
               void'(expected_levels.pop_front());
            end
         end
      end
   end

endmodule

// ----- tb/i2c_master_byte_engine_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core_tb
// drives tick and command transactions into the byte engine under several
// timing register settings and random idling, checking via the checker
// ----------------------------------------------------------------------------

module i2c_master_byte_engine_core_tb;
   import i2cmb_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  end_of_run  = 1'b0;
   int unsigned           failures;

   int unsigned req_count   = 0;
   int unsigned rsp_count   = 0;
   int unsigned done_count  = 0;
   int unsigned items_sent  = 0;
   int unsigned quiet       = 0;
   logic        last_busy   = 1'b0;
   int unsigned send_gap_pct = 0;
   int unsigned stall_pct    = 0;
   int unsigned overlap_pct  = 0;

   always #1 clock = ~clock;

   i2c_master_byte_engine_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   i2c_master_byte_engine_core_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .end_of_run  (end_of_run),
      .failures    (failures)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // transaction counts and watchdog
   always @(posedge clock) begin
      if (req_valid && !req_stall)
         req_count <= req_count + 1;
      if (rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         last_busy <= rsp_data.busy_res;
         if (rsp_data.done_res)
            done_count <= done_count + 1;
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("[i2c_master_byte_engine_core] ERROR");
         $finish;
      end
   end

   function automatic req_payload_type command_item(input logic [CMD_W-1:0] c,
         input logic [DATA_BITS-1:0] d, input logic a, input logic s);
      return '{req_type: 1'b1, command: c, wr_data: d, send_ack: a, sda_in: s};
   endfunction

   task automatic send_item(input req_payload_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      items_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   // tick with garbage in the command fields, sda mostly released
   task automatic send_tick();
      send_item('{req_type: 1'b0, command: 3'($urandom), wr_data: 8'($urandom),
                  send_ack: 1'($urandom), sda_in: ($urandom_range(3) != 0)});
   endtask

   task automatic run_cmd(input logic [CMD_W-1:0] c, input logic [DATA_BITS-1:0] d,
                          input logic a, input logic s);
      int unsigned seen;
      seen = done_count;
      send_item(command_item(c, d, a, s));
      if ($urandom_range(99) < overlap_pct)
         send_item(command_item(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)));
      while (done_count == seen)
         send_tick();
   endtask

   // drain responses and tick until the engine reports idle
   task automatic settle();
      int unsigned seen;
      forever begin
         @(negedge clock);
         req_valid <= 1'b0;
         while (rsp_count != req_count)
            @(posedge clock);
         if (!last_busy)
            break;
         seen = done_count;
         while (done_count == seen)
            send_tick();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_timing(input logic [TICK_W-1:0] v[6]);
      logic [CSR_IDX_W-1:0] idx[6];
      idx = '{REG_HOLD, REG_LOW_REST, REG_HIGH, REG_HIGH_REST, REG_IDLE, REG_START_SETUP};
      for (int i = 0; i < 6; i++) begin
         @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_index   <= idx[i];
         csr_wr_data <= v[i];
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_timing(input int unsigned hi);
      logic [TICK_W-1:0] v[6];
      foreach (v[i])
         v[i] = TICK_W'($urandom_range(hi, 1));
      set_timing(v);
   endtask

   task automatic random_transfer();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(99);
      if (pick < 5) begin
         send_item(command_item(3'($urandom_range(7, 5)), 8'($urandom),
                                1'($urandom), 1'($urandom)));
      end else if (pick < 15) begin
         run_cmd(3'($urandom_range(4)), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
         n = $urandom_range(3, 1);
         run_cmd(CMD_START, 8'($urandom), 1'($urandom), ($urandom_range(15) != 0));
         run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
         if ($urandom_range(1)) begin
            repeat (n) run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            run_cmd(CMD_REP, 8'($urandom), 1'($urandom), 1'($urandom));
            run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
            for (int k = 0; k < n; k++)
               run_cmd(CMD_READ, 8'($urandom), (k < n - 1), 1'($urandom));
         end
         run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned target;
      target = items_sent + count;
      while (items_sent < target)
         random_transfer();
      settle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset timing, sender idles lightly and receiver heavily
      send_gap_pct = 12;
      stall_pct    = 50;
      send_tick();
      send_item(command_item(3'd5, 8'hA5, 1'b1, 1'b1));
      send_item(command_item(3'd7, 8'h5A, 1'b0, 1'b0));
      run_cmd(CMD_START, 8'h00, 1'b0, 1'b0);
      overlap_pct = 100;
      run_cmd(CMD_START, 8'hFF, 1'b1, 1'b1);
      overlap_pct = 0;
      run_cmd(CMD_WRITE, 8'hFF, 1'b0, 1'b1);
      run_cmd(CMD_WRITE, 8'h00, 1'b1, 1'b0);
      run_cmd(CMD_WRITE, 8'h80, 1'b0, 1'b1);
      run_cmd(CMD_REP, 8'h7F, 1'b0, 1'b1);
      run_cmd(CMD_READ, 8'h01, 1'b1, 1'b0);
      run_cmd(CMD_READ, 8'hFE, 1'b0, 1'b1);
      run_cmd(CMD_STOP, 8'h00, 1'b0, 1'b1);
      run_cmd(CMD_REP, 8'h00, 1'b1, 1'b0);
      run_cmd(CMD_STOP, 8'h00, 1'b1, 1'b0);
      settle();

      overlap_pct = 3;
      set_timing('{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1});
      random_phase(250);

      // zero counts behave as one tick
      send_gap_pct = 50;
      stall_pct    = 12;
      set_timing('{8'd0, 8'd3, 8'd0, 8'd1, 8'd0, 8'd0});
      random_phase(200);

      random_timing(5);
      random_phase(250);

      // longest waits on a single start
      send_gap_pct = 0;
      stall_pct    = 0;
      overlap_pct  = 0;
      set_timing('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
      run_cmd(CMD_START, 8'h00, 1'b0, 1'b1);
      settle();

      overlap_pct = 3;
      random_timing(3);
      random_phase(300);

      repeat (10) @(posedge clock);
      @(negedge clock);
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);

      $display("summary: %0d request and %0d response transactions, %0d bus commands completed",
               req_count, rsp_count, done_count);
      $display("summary: timing at reset, minimum, zero, random and maximum register values");
      if (failures == 0)
         $display("[i2c_master_byte_engine_core] OK");
      else
         $display("[i2c_master_byte_engine_core] ERROR");
      $finish;
   end

endmodule
